FILE: hdl/afx_pkg.sv
// Shared types and codes for the acknowledged frame exchange retry core.
package afx_pkg;

    // Event codes on the input channel
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_TX_DONE = 2'd1;
    localparam logic [1:0] ACT_FRAME   = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    // Arrived frame kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_CTS   = 2'd2;

    // Exchange outcome codes
    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_SUCCESS = 2'd1;
    localparam logic [1:0] OUT_FAILURE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CW_MIN      = 2'd0;
    localparam logic [1:0] CFG_CW_MAX      = 2'd1;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd2;
    localparam logic [1:0] CFG_MODE        = 2'd3;

    // Exchange modes
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_RTS  = 1'b1;

    // Field masks applied on configuration writes
    localparam logic [9:0] CW_FIELD_MASK    = 10'h3FF;
    localparam logic [7:0] RETRY_FIELD_MASK = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SEND      = 3'd1,
        PH_WAIT      = 3'd2,
        PH_DONE_OK   = 3'd3,
        PH_DONE_FAIL = 3'd4
    } phase_t;

    // Control part of one result transaction
    typedef struct packed {
        logic       send_frame;
        logic       retry_bit;
        logic       arm_timer;
        logic       pass_up;
        logic [1:0] outcome;
    } flags_t;

endpackage

FILE: hdl/afx_input_stage.sv
// Input register of the exchange core: holds one accepted event transaction.
module afx_input_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [1:0] frame_kind,
    input  logic       advance,
    output logic       held_valid,
    output logic [1:0] held_action,
    output logic [1:0] held_kind
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] action_reg;
    logic [1:0] kind_reg;

    // Take a new transaction whenever the held one leaves or none is held
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            kind_reg   <= frame_kind;
        end
    end

    assign held_valid  = valid_reg;
    assign held_action = action_reg;
    assign held_kind   = kind_reg;

endmodule

FILE: hdl/afx_exchange_fsm.sv
// Exchange state machine with configuration registers, window and retry count.
module afx_exchange_fsm #(
    parameter int WINDOW_BITS = 10,
    parameter int RETRY_BITS  = 8,
    parameter int CFG_BITS    = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data,
    input  logic                   step,
    input  logic [1:0]             action,
    input  logic [1:0]             frame_kind,
    output afx_pkg::flags_t        flags,
    output logic [WINDOW_BITS-1:0] send_window
);

    logic [WINDOW_BITS-1:0] cw_min_reg;
    logic [WINDOW_BITS-1:0] cw_max_reg;
    logic [RETRY_BITS-1:0]  max_retries_reg;
    logic                   mode_reg;

    afx_pkg::phase_t        phase_reg;
    afx_pkg::phase_t        phase_next;
    logic [WINDOW_BITS-1:0] window_reg;
    logic [WINDOW_BITS-1:0] window_next;
    logic [RETRY_BITS-1:0]  retries_reg;
    logic [RETRY_BITS-1:0]  retries_next;

    logic [WINDOW_BITS:0]   doubled;
    logic [WINDOW_BITS-1:0] grown;
    logic [1:0]             wanted_kind;
    logic                   can_start;
    logic                   can_retry;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_min_reg      <= WINDOW_BITS'(15);
            cw_max_reg      <= WINDOW_BITS'(1023);
            max_retries_reg <= RETRY_BITS'(7);
            mode_reg        <= afx_pkg::MODE_DATA;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                afx_pkg::CFG_CW_MIN:
                    cw_min_reg <= cfg_data[WINDOW_BITS-1:0]
                                  & WINDOW_BITS'(afx_pkg::CW_FIELD_MASK);
                afx_pkg::CFG_CW_MAX:
                    cw_max_reg <= cfg_data[WINDOW_BITS-1:0]
                                  & WINDOW_BITS'(afx_pkg::CW_FIELD_MASK);
                afx_pkg::CFG_MAX_RETRIES:
                    max_retries_reg <= cfg_data[RETRY_BITS-1:0]
                                       & RETRY_BITS'(afx_pkg::RETRY_FIELD_MASK);
                afx_pkg::CFG_MODE:
                    mode_reg <= cfg_data[0];
                default:
                    mode_reg <= mode_reg;
            endcase
        end
    end

    // Grow the window as 2w+1, clamped to cw_max; keep it once at the limit
    always_comb
    begin
        doubled = {window_reg, 1'b1};
        if (window_reg >= cw_max_reg)
        begin
            grown = window_reg;
        end
        else if (doubled > {1'b0, cw_max_reg})
        begin
            grown = cw_max_reg;
        end
        else
        begin
            grown = doubled[WINDOW_BITS-1:0];
        end
    end

    assign wanted_kind = (mode_reg == afx_pkg::MODE_RTS) ? afx_pkg::KIND_CTS
                                                         : afx_pkg::KIND_ACK;
    assign can_start   = phase_reg inside {afx_pkg::PH_IDLE, afx_pkg::PH_DONE_OK,
                                           afx_pkg::PH_DONE_FAIL};
    assign can_retry   = retries_reg < max_retries_reg;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        retries_next = retries_reg;
        case (action)
            afx_pkg::ACT_START:
            begin
                if (can_start)
                begin
                    phase_next   = afx_pkg::PH_SEND;
                    window_next  = cw_min_reg;
                    retries_next = '0;
                end
            end
            afx_pkg::ACT_TX_DONE:
            begin
                if (phase_reg == afx_pkg::PH_SEND)
                begin
                    phase_next = afx_pkg::PH_WAIT;
                end
            end
            afx_pkg::ACT_FRAME:
            begin
                if (phase_reg == afx_pkg::PH_WAIT)
                begin
                    phase_next = (frame_kind == wanted_kind) ? afx_pkg::PH_DONE_OK
                                                             : afx_pkg::PH_DONE_FAIL;
                end
            end
            afx_pkg::ACT_TIMEOUT:
            begin
                if (phase_reg == afx_pkg::PH_WAIT)
                begin
                    if (can_retry)
                    begin
                        phase_next   = afx_pkg::PH_SEND;
                        window_next  = grown;
                        retries_next = retries_reg + RETRY_BITS'(1);
                    end
                    else
                    begin
                        phase_next = afx_pkg::PH_DONE_FAIL;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Result fields
    always_comb
    begin
        flags       = '0;
        send_window = '0;
        case (action)
            afx_pkg::ACT_START:
            begin
                if (can_start)
                begin
                    flags.send_frame = 1'b1;
                    send_window      = cw_min_reg;
                end
            end
            afx_pkg::ACT_TX_DONE:
            begin
                flags.arm_timer = (phase_reg == afx_pkg::PH_SEND);
            end
            afx_pkg::ACT_FRAME:
            begin
                if (phase_reg == afx_pkg::PH_SEND)
                begin
                    flags.pass_up = 1'b1;
                end
                else if (phase_reg == afx_pkg::PH_WAIT)
                begin
                    if (frame_kind == wanted_kind)
                    begin
                        flags.outcome = afx_pkg::OUT_SUCCESS;
                    end
                    else
                    begin
                        flags.pass_up = 1'b1;
                        flags.outcome = afx_pkg::OUT_FAILURE;
                    end
                end
            end
            afx_pkg::ACT_TIMEOUT:
            begin
                if (phase_reg == afx_pkg::PH_WAIT)
                begin
                    if (can_retry)
                    begin
                        flags.send_frame = 1'b1;
                        flags.retry_bit  = (mode_reg == afx_pkg::MODE_DATA);
                        send_window      = grown;
                    end
                    else
                    begin
                        flags.outcome = afx_pkg::OUT_FAILURE;
                    end
                end
            end
            default:
            begin
                flags = '0;
            end
        endcase
    end

    // Advance exchange state on each processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= afx_pkg::PH_IDLE;
            window_reg  <= '0;
            retries_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            retries_reg <= retries_next;
        end
    end

endmodule

FILE: hdl/afx_result_stage.sv
// Output register of the exchange core: holds one result transaction.
module afx_result_stage #(
    parameter int WINDOW_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  afx_pkg::flags_t        flags,
    input  logic [WINDOW_BITS-1:0] window,
    output logic                   slot_free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   send_frame,
    output logic [WINDOW_BITS-1:0] send_window,
    output logic                   retry_bit,
    output logic                   arm_timer,
    output logic                   pass_up,
    output logic [1:0]             outcome
);

    logic                   valid_reg;
    logic                   valid_next;
    afx_pkg::flags_t        flags_reg;
    logic [WINDOW_BITS-1:0] window_reg;

    // Slot frees when empty or when the receiver takes the held transaction
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (slot_free)
        begin
            valid_next = load;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (load && slot_free)
        begin
            flags_reg  <= flags;
            window_reg <= window;
        end
    end

    assign out_valid   = valid_reg;
    assign send_frame  = flags_reg.send_frame;
    assign send_window = window_reg;
    assign retry_bit   = flags_reg.retry_bit;
    assign arm_timer   = flags_reg.arm_timer;
    assign pass_up     = flags_reg.pass_up;
    assign outcome     = flags_reg.outcome;

endmodule

FILE: hdl/acked_frame_exchange_retry_core.sv
// Top level of the acknowledged frame exchange sender with retry and backoff.
//
// Usage:
//   Input channel (in_valid/in_ready, action, frame_kind) carries one MAC event
//   per transaction: start, transmission finished, frame arrived, reply timeout.
//   Every event yields exactly one result transaction on the output channel
//   (out_valid/out_ready): send_frame with send_window and retry_bit, arm_timer,
//   pass_up and the exchange outcome.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   cw_min, cw_max, max_retries and exchange_mode; cfg_ready is always high.
//   Write it only while no event is in flight.
// Timing:
//   An event is registered on acceptance, processed against the exchange state
//   once the output slot is free and its result is registered in the output
//   register, which raises out_valid. One event per cycle is taken while
//   out_ready stays high; the state update is a single combinational pass.
// Reset:
//   rst_n clears both stage valid flags and the exchange state to idle and
//   reloads the configuration defaults (15, 1023, 7, data mode).
// Stall:
//   While out_ready is low the result is held; the input register takes one more
//   event only if empty, after which in_ready drops until the result is taken.
module acked_frame_exchange_retry_core #(
    parameter int WINDOW_BITS = 10,
    parameter int RETRY_BITS  = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             action,
    input  logic [1:0]             frame_kind,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   send_frame,
    output logic [WINDOW_BITS-1:0] send_window,
    output logic                   retry_bit,
    output logic                   arm_timer,
    output logic                   pass_up,
    output logic [1:0]             outcome,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [((WINDOW_BITS > RETRY_BITS) ? WINDOW_BITS : RETRY_BITS)-1:0] cfg_data
);

    localparam int CFG_BITS = (WINDOW_BITS > RETRY_BITS) ? WINDOW_BITS : RETRY_BITS;

    logic                   slot_free;
    logic                   held_valid;
    logic [1:0]             held_action;
    logic [1:0]             held_kind;
    afx_pkg::flags_t        step_flags;
    logic [WINDOW_BITS-1:0] step_window;

    assign cfg_ready = 1'b1;

    afx_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .frame_kind  (frame_kind),
        .advance     (slot_free),
        .held_valid  (held_valid),
        .held_action (held_action),
        .held_kind   (held_kind)
    );

    afx_exchange_fsm #(
        .WINDOW_BITS (WINDOW_BITS),
        .RETRY_BITS  (RETRY_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (held_valid && slot_free),
        .action      (held_action),
        .frame_kind  (held_kind),
        .flags       (step_flags),
        .send_window (step_window)
    );

    afx_result_stage #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (held_valid),
        .flags       (step_flags),
        .window      (step_window),
        .slot_free   (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .send_frame  (send_frame),
        .send_window (send_window),
        .retry_bit   (retry_bit),
        .arm_timer   (arm_timer),
        .pass_up     (pass_up),
        .outcome     (outcome)
    );

endmodule

FILE: hdl/afx_checker.sv
// Port-level checker for the exchange core, bound to the top level.
module afx_checker #(
    parameter int WINDOW_BITS = 10
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   send_frame,
    input logic [WINDOW_BITS-1:0] send_window,
    input logic                   retry_bit,
    input logic                   arm_timer,
    input logic                   pass_up,
    input logic [1:0]             outcome
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(send_frame)
            && $stable(send_window) && $stable(outcome))
        else $error("result changed while stalled");

    // No window or retry mark without a transmission request
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_frame |-> send_window == '0 && !retry_bit)
        else $error("window or retry bit without send request");

    // A result asks for at most one of send, arm and outcome
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({send_frame, arm_timer, outcome != afx_pkg::OUT_NONE}))
        else $error("conflicting result actions");

    // Success never passes the frame up
    a_success_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome == afx_pkg::OUT_SUCCESS |-> !pass_up)
        else $error("pass up on success");

endmodule

bind acked_frame_exchange_retry_core afx_checker #(
    .WINDOW_BITS (WINDOW_BITS)
) u_afx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .send_frame  (send_frame),
    .send_window (send_window),
    .retry_bit   (retry_bit),
    .arm_timer   (arm_timer),
    .pass_up     (pass_up),
    .outcome     (outcome)
);
